// File: src/fdiv_pkg.sv
// Shared types and constants for the binary32 divider.
package fdiv_pkg;

	localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
	localparam logic [30:0] INF_MAG = 31'h7F80_0000;
	localparam int QUO_STEPS = 26;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_STEPS / STEPS_PER_STAGE;

	// Per-item state carried through the division stages.
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        sign;
		logic signed [10:0] exp;
		logic [24:0] rem;
		logic [23:0] sb;
		logic [26:0] q;
	} div_item_t;

	// Counts leading zeros of a 24-bit significand (for subnormal inputs).
	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && v[i]) begin
				found = 1'b1;
				n = 5'(23 - i);
			end
		end
		return n;
	endfunction

endpackage

// File: src/float32_divider.sv
// Pipelined IEEE 754 binary32 divider with round to nearest even.
// Throughput: one beat per cycle while the output is not stalled; stage 1 unpacks
// and normalizes, thirteen stages each retire two quotient bits of the restoring
// division, then one stage rounds and packs and a final stage holds the output register.
// Reset (arst_n low, asynchronous) clears all valid bits; data needs no reset.
module float32_divider
	import fdiv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] dividend_bits, [63:32] divisor_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] quotient_bits
);

	// The whole pipe advances together; a bubble at the output lets it move.
	logic advance;
	assign advance = !m_tvalid || m_tready;
	assign s_tready = advance;

	// Stage 1: special cases, normalization, first subtraction.
	logic [31:0] a, b;
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic [23:0] sa_raw, sb_raw, sa, sb;
	logic [4:0]  lza, lzb;
	logic signed [10:0] ua, ub, e0;
	logic        sgn, spec;
	logic [31:0] spec_bits;
	logic [24:0] rem0;
	div_item_t   item0;

	always_comb begin
		a = s_tdata[31:0];
		b = s_tdata[63:32];
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		sgn = a[31] ^ b[31];
		spec = 1'b1;
		spec_bits = {sgn, 31'd0};
		if (ea == 8'hFF) begin
			if (fa != 23'd0) spec_bits = a | QUIET_BIT;
			else if (eb == 8'hFF) spec_bits = (fb != 23'd0) ? (b | QUIET_BIT) : QNAN_DEFAULT;
			else spec_bits = {sgn, INF_MAG};
		end else if (eb == 8'hFF) begin
			spec_bits = (fb != 23'd0) ? (b | QUIET_BIT) : {sgn, 31'd0};
		end else if (ea == 8'd0 && fa == 23'd0) begin
			spec_bits = (eb == 8'd0 && fb == 23'd0) ? QNAN_DEFAULT : {sgn, 31'd0};
		end else if (eb == 8'd0 && fb == 23'd0) begin
			spec_bits = {sgn, INF_MAG};
		end else begin
			spec = 1'b0;
		end
		sa_raw = {(ea != 8'd0), fa};
		sb_raw = {(eb != 8'd0), fb};
		lza = lzc24(sa_raw);
		lzb = lzc24(sb_raw);
		sa = sa_raw << lza;
		sb = sb_raw << lzb;
		ua = ((ea != 8'd0) ? (11'(ea) - 11'sd127) : -11'sd126) - 11'(lza);
		ub = ((eb != 8'd0) ? (11'(eb) - 11'sd127) : -11'sd126) - 11'(lzb);
		e0 = ua - ub + 11'sd127;
		if (sa < sb) begin
			rem0 = {sa, 1'b0} - {1'b0, sb};
			e0 = e0 - 11'sd1;
		end else begin
			rem0 = {1'b0, sa} - {1'b0, sb};
		end
		item0.special = spec;
		item0.special_bits = spec_bits;
		item0.sign = sgn;
		item0.exp = e0;
		item0.rem = rem0;
		item0.sb = sb;
		item0.q = 27'd1;
	end

	logic      v_s1;
	div_item_t d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_s1 <= item0;
		end
	end

	// Division stages: each retires STEPS_PER_STAGE quotient bits.
	logic      v_div [DIV_STAGES+1];
	div_item_t d_div [DIV_STAGES+1];
	assign v_div[0] = v_s1;
	assign d_div[0] = d_s1;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_item_t nxt;
		always_comb begin
			logic [25:0] r2;
			nxt = d_div[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				r2 = {nxt.rem, 1'b0};
				nxt.q = {nxt.q[25:0], 1'b0};
				if (r2 >= {2'b00, nxt.sb}) begin
					r2 = r2 - {2'b00, nxt.sb};
					nxt.q[0] = 1'b1;
				end
				nxt.rem = r2[24:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div[g+1] <= 1'b0;
			end else if (advance) begin
				v_div[g+1] <= v_div[g];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				d_div[g+1] <= nxt;
			end
		end
	end

	// Rounding and packing. The rounded significand keeps one extra bit so a
	// carry out of the fraction bumps the exponent.
	div_item_t   fin;
	logic [26:0] qs, qd;
	logic signed [10:0] sh;
	logic [26:0] lost_mask;
	logic [24:0] qr;
	logic [2:0]  low3;
	logic [31:0] mag, packed_bits;

	always_comb begin
		fin = d_div[DIV_STAGES];
		qs = {fin.q[26:1], fin.q[0] | (fin.rem != 25'd0)};
		sh = 11'sd1 - fin.exp;
		qd = qs;
		lost_mask = 27'd0;
		if (fin.exp <= 11'sd0) begin
			if (sh > 11'sd26) begin
				qd = {26'd0, (qs != 27'd0)};
			end else begin
				lost_mask = (27'd1 << sh[4:0]) - 27'd1;
				qd = (qs >> sh[4:0]) | {26'd0, ((qs & lost_mask) != 27'd0)};
			end
		end
		low3 = qd[2:0];
		qr = {1'b0, qd[26:3]};
		if (low3 > 3'd4 || (low3 == 3'd4 && qd[3])) qr = qr + 25'd1;
		if (fin.exp <= 11'sd0) mag = {7'd0, qr};
		else mag = ({fin.exp[8:0] - 9'd1, 23'd0}) + {7'd0, qr};
		if (mag >= {1'b0, INF_MAG}) mag = {1'b0, INF_MAG};
		if (fin.exp >= 11'sd255) mag = {1'b0, INF_MAG};
		packed_bits = fin.special ? fin.special_bits : {fin.sign, mag[30:0]};
	end

	logic        v_s15;
	logic [31:0] r_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (advance) begin
			v_s15 <= v_div[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			r_s15 <= packed_bits;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= r_s15;
		end
	end

endmodule

// File: src/fdiv_checker.sv
// Port-level checker for the binary32 divider and its bind.
module fdiv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled output beat keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// The input side stalls only while the output beat is held.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// Taking an output beat frees the input side.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while output ready");

endmodule

bind float32_divider fdiv_checker u_fdiv_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: test/tb_float32_divider.sv
// Testbench for the pipelined binary32 divider: directed special cases and random operands.
`timescale 1ns / 1ps

module tb_float32_divider;
	import fdiv_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // [31:0] dividend_bits, [63:32] divisor_bits
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [31:0] quotient_bits

	logic [31:0] quotients_due[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	// When set, both sides stop idling for a stretch of the run.
	bit no_idle = 1'b0;

	float32_divider dut (.*);

	always #5 clk = ~clk;

	// Prediction: normalize a significand and return its unbiased exponent.
	function automatic logic [23:0] normalize(input logic [7:0] ef, input logic [22:0] fr,
		output int unb);
		logic [23:0] s;
		s = {ef != 8'd0, fr};
		unb = (ef != 8'd0) ? int'(ef) - 127 : -126;
		while (s != 24'd0 && !s[23]) begin
			s = s << 1;
			unb--;
		end
		return s;
	endfunction

	// Rounds a 27-bit quotient with guard, round and sticky bits, then packs it.
	function automatic logic [31:0] round_pack(input logic sgn, input int e, input logic [31:0] q);
		logic [31:0] mag;
		logic [2:0]  low3;
		int sh;
		if (e >= 255) return {sgn, INF_MAG};
		if (e <= 0) begin
			sh = 1 - e;
			if (sh > 26) q = (q != 0) ? 32'd1 : 32'd0;
			else q = (q >> sh) | ((q & ((32'd1 << sh) - 1)) != 0);
			e = 0;
		end
		low3 = q[2:0];
		q = q >> 3;
		if (low3 > 3'd4 || (low3 == 3'd4 && q[0])) q = q + 1;
		mag = (e == 0) ? q : ((32'(e - 1) << 23) + q);
		if (mag >= {1'b0, INF_MAG}) mag = {1'b0, INF_MAG};
		return {sgn, 31'd0} | mag;
	endfunction

	function automatic logic [31:0] divide_bits(input logic [31:0] a, input logic [31:0] b);
		logic [7:0]  ea, eb;
		logic [22:0] fa, fb;
		logic        sgn;
		logic [23:0] sa, sb;
		logic [31:0] rem, q;
		int ua, ub, e;
		ea = a[30:23]; eb = b[30:23];
		fa = a[22:0];  fb = b[22:0];
		sgn = a[31] ^ b[31];
		if (ea == 8'hFF) begin
			if (fa != 0) return a | QUIET_BIT;
			if (eb == 8'hFF) return (fb != 0) ? (b | QUIET_BIT) : QNAN_DEFAULT;
			return {sgn, INF_MAG};
		end
		if (eb == 8'hFF) return (fb != 0) ? (b | QUIET_BIT) : {sgn, 31'd0};
		if (ea == 0 && fa == 0) return (eb == 0 && fb == 0) ? QNAN_DEFAULT : {sgn, 31'd0};
		if (eb == 0 && fb == 0) return {sgn, INF_MAG};
		sa = normalize(ea, fa, ua);
		sb = normalize(eb, fb, ub);
		e = ua - ub + 127;
		if (sa < sb) begin
			rem = {sa, 1'b0};
			e--;
		end else begin
			rem = sa;
		end
		rem = rem - sb;
		q = 1;
		for (int i = 0; i < QUO_STEPS; i++) begin
			q = q << 1;
			rem = rem << 1;
			if (rem >= sb) begin
				rem = rem - sb;
				q[0] = 1'b1;
			end
		end
		if (rem != 0) q[0] = 1'b1;
		return round_pack(sgn, e, q);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %08h expected %08h", what, got, want);
	endtask

	// Sends one operand pair as a beat, idling first at random.
	task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
		while (!no_idle && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		quotients_due.push_back(divide_bits(a, b));
		sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Receiver: random back-pressure, each beat checked against the oldest quotient.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				received++;
				if (quotients_due.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata, 32'd0);
				end else begin
					want = quotients_due.pop_front();
					if (m_tdata !== want) report_mismatch("quotient_bits", m_tdata, want);
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= 35);
		end
	end

	// Operand generator biased toward exponent extremes and specials.
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:23] = 8'(($urandom_range(1) != 0) ? $urandom_range(254, 230)
				: $urandom_range(25, 1));
			3: v[22:0] = ($urandom_range(1) != 0) ? 23'h0 : 23'h7FFFFF;
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_special_cases();
		logic [31:0] vals[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
			32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'hC040_0000};
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				if (i != j || i < 2) send_pair(vals[$urandom_range(11)], vals[$urandom_range(11)]);
		send_pair(32'h7F7F_FFFF, 32'h0000_0001);  // overflow
		send_pair(32'h0000_0001, 32'h7F7F_FFFF);  // underflow to zero
		send_pair(32'h0080_0000, 32'h3FFF_FFFF);  // rounds into subnormals
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_operands(input int count);
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= 600 && i < 800);
			send_pair(pick_operand(), pick_operand());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_random_operands(1525);
		s_tvalid <= 1'b0;
		while (quotients_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d operand pairs (specials, extremes, random), checked %0d quotients.",
			sent, received);
		if (errors == 0) begin
			$display("tb_float32_divider OK");
		end else begin
			$display("tb_float32_divider NOT OK");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_float32_divider NOT OK");
		$finish;
	end

endmodule
